// ----- rtl/core/bpos_pkg.sv -----
// bpos_pkg: widths, register indexes, reset values and limits for the ball position block
// shared by bpos_div, bpos_sqrt and ball_position_from_pixel_circle; no dependencies
`timescale 1ns / 1ps

package bpos_pkg;

    // field and register widths
    localparam int FOC_W     = 20;
    localparam int BALL_W    = 10;
    localparam int MNT_W     = 12;
    localparam int RAD_W     = 11;
    localparam int RES_W     = 24;
    localparam int QUO_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BALL_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_OFF   = 3'd5;

    // reset values
    localparam logic [FOC_W-1:0]  FOCAL_X_RST     = 20'd165440;
    localparam logic [FOC_W-1:0]  FOCAL_Y_RST     = 20'd166400;
    localparam logic [FOC_W-1:0]  PRINCIPAL_X_RST = 20'd82253;
    localparam logic [FOC_W-1:0]  PRINCIPAL_Y_RST = 20'd62835;
    localparam logic [BALL_W-1:0] BALL_RST        = 10'd75;
    localparam logic [MNT_W-1:0]  MOUNT_RST       = 12'd250;

    // saturation limits (magnitudes)
    localparam logic [RES_W-1:0] POS_MAX_MAG = 24'h7FFFFF;
    localparam logic [RES_W-1:0] POS_MIN_MAG = 24'h800000;
    localparam logic [RES_W-1:0] RANGE_MAX   = 24'hFFFFFF;

    // side data carried alongside the square root
    typedef struct packed {
        logic             neg;
        logic             err;
        logic [RES_W-1:0] pos_x;
        logic [RES_W-1:0] pos_y;
    } t_side;

endpackage

// ----- rtl/core/bpos_div.sv -----
// bpos_div: pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on bpos_pkg (quotient width)
`timescale 1ns / 1ps

module bpos_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 21,
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_vld,
    output logic [bpos_pkg::QUO_W-1:0]   o_q,
    output logic                         o_ovf,
    output logic [TAG_W-1:0]             o_tag
);

    localparam int QW   = bpos_pkg::QUO_W;
    localparam int HI_W = NUM_W - QW;
    localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    logic             r_vld [0:QW];
    logic [DEN_W-1:0] r_rem [0:QW];
    logic [QW-1:0]    r_low [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic [DEN_W-1:0] r_den [0:QW];
    logic             r_ovf [0:QW];
    logic [TAG_W-1:0] r_tag [0:QW];

    assign hi_ext  = CW'(i_num[NUM_W-1:QW]);
    assign den_ext = CW'(i_den);

    // entry stage: quotient overflow when the high part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= hi_ext[DEN_W-1:0];
            r_low[0] <= i_num[QW-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= (hi_ext >= den_ext);
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           ge;

        assign t    = {r_rem[k], r_low[k][QW-1]};
        assign diff = t - {1'b0, r_den[k]};
        assign ge   = (t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_tag = r_tag[QW];

endmodule

// ----- rtl/core/bpos_sqrt.sv -----
// bpos_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on bpos_pkg (root width); returns root and remainder for rounding
`timescale 1ns / 1ps

module bpos_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [2*bpos_pkg::RES_W-1:0]  i_rad,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_vld,
    output logic [bpos_pkg::RES_W-1:0]    o_root,
    output logic [bpos_pkg::RES_W:0]      o_rem,
    output logic [TAG_W-1:0]              o_tag
);

    localparam int RW = bpos_pkg::RES_W;

    logic             r_vld  [0:RW];
    logic [2*RW-1:0]  r_rad  [0:RW];
    logic [RW:0]      r_rem  [0:RW];
    logic [RW-1:0]    r_root [0:RW];
    logic [TAG_W-1:0] r_tag  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RW+2:0] t;
        logic [RW+2:0] trial;
        logic [RW+2:0] diff;
        logic          ge;

        // bring down the next bit pair, try root*4+1
        assign t     = {r_rem[k], r_rad[k][2*RW-1 -: 2]};
        assign trial = {1'b0, r_root[k], 2'b01};
        assign diff  = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][2*RW-3:0], 2'b00};
                r_rem[k+1]  <= ge ? diff[RW:0] : t[RW:0];
                r_root[k+1] <= {r_root[k][RW-2:0], ge};
                r_tag[k+1]  <= r_tag[k];
            end
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_rem  = r_rem[RW];
    assign o_tag  = r_tag[RW];

endmodule

// ----- rtl/core/ball_position_from_pixel_circle.sv -----
// ball_position_from_pixel_circle: pinhole back-projection of a circle to ball x, y and range
// depends on bpos_pkg, bpos_div (three lanes) and bpos_sqrt
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------------------
//  input     | in        | i_valid / o_ready   | i_pixel_x, i_pixel_y, i_pixel_radius
//  result    | out       | o_valid / i_ready   | o_pos_x_mm, o_pos_y_mm, o_range_mm, o_error
//  config    | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// one word accepted per cycle while o_ready is high; a word passes through 60 registers:
// 4 setup, 25 divider, 4 clamp, square and sum, 25 root, final and output reg
// most of them belong to the one-bit-per-stage divider and square root pipelines
// reset is synchronous active low; it clears valid bits and restores the register values
// an output register plus one skid entry sit behind the pipeline; the pipeline freezes
// only while the skid entry is full, so o_ready never depends on i_ready
`timescale 1ns / 1ps

module ball_position_from_pixel_circle #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [PIXEL_BITS-1:0]               i_pixel_x,
    input  logic [PIXEL_BITS-1:0]               i_pixel_y,
    input  logic [bpos_pkg::RAD_W-1:0]          i_pixel_radius,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bpos_pkg::RES_W-1:0]   o_pos_x_mm,
    output logic signed [bpos_pkg::RES_W-1:0]   o_pos_y_mm,
    output logic [bpos_pkg::RES_W-1:0]          o_range_mm,
    output logic                                o_error,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bpos_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpos_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int FW    = bpos_pkg::FOC_W;
    localparam int BW    = bpos_pkg::BALL_W;
    localparam int MW    = bpos_pkg::MNT_W;
    localparam int RDW   = bpos_pkg::RAD_W;
    localparam int RW    = bpos_pkg::RES_W;
    localparam int QW    = bpos_pkg::QUO_W;
    localparam int PX_W  = PIXEL_BITS + 8;                 // pixel in 1/256 units
    localparam int D_W   = (PX_W > FW) ? PX_W : FW;        // offset magnitude
    localparam int FXB_W = FW + BW;                        // focal_x * ball radius
    localparam int DXB_W = D_W + BW;                       // dx * ball radius
    localparam int FYR_W = FW + RDW;                       // focal_y * pixel radius
    localparam int DYF_W = D_W + FXB_W;                    // dy * focal_x * ball radius
    localparam int NZ_W  = FXB_W + 2;
    localparam int NX_W  = DXB_W + 2;
    localparam int NY_W  = DYF_W + 2;
    localparam int DZ_W  = RDW + 10;                       // 1024 * r
    localparam int DY_W  = FYR_W + 10;                     // 1024 * focal_y * r
    localparam int SQ_W  = 2 * RW;
    localparam int SIDE_W = $bits(bpos_pkg::t_side);

    // ---------------------------------------------------------------- config registers
    logic [FW-1:0] r_focal_x;
    logic [FW-1:0] r_focal_y;
    logic [FW-1:0] r_prin_x;
    logic [FW-1:0] r_prin_y;
    logic [BW-1:0] r_ball;
    logic [MW-1:0] r_mount;
    logic [SQ_W-1:0] r_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= bpos_pkg::FOCAL_X_RST;
            r_focal_y <= bpos_pkg::FOCAL_Y_RST;
            r_prin_x  <= bpos_pkg::PRINCIPAL_X_RST;
            r_prin_y  <= bpos_pkg::PRINCIPAL_Y_RST;
            r_ball    <= bpos_pkg::BALL_RST;
            r_mount   <= bpos_pkg::MOUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpos_pkg::CFG_FOCAL_X:     r_focal_x <= i_cfg_data;
                bpos_pkg::CFG_FOCAL_Y:     r_focal_y <= i_cfg_data;
                bpos_pkg::CFG_PRINCIPAL_X: r_prin_x  <= i_cfg_data;
                bpos_pkg::CFG_PRINCIPAL_Y: r_prin_y  <= i_cfg_data;
                bpos_pkg::CFG_BALL_RADIUS: r_ball    <= i_cfg_data[BW-1:0];
                bpos_pkg::CFG_MOUNT_OFF:   r_mount   <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // mount offset squared, recomputed every cycle; the user must change config only while idle (not enforced here)
    always_ff @(posedge i_clk) begin
        r_m2 <= SQ_W'(r_mount * r_mount);
    end

    // ---------------------------------------------------------------- pipeline control
    logic en;
    logic r_skid_vld;
    logic r_out_vld;

    // the whole pipeline moves unless the skid entry is holding a word
    assign en      = !r_skid_vld;
    assign o_ready = en;

    // ---------------------------------------------------------------- stage 1: offsets
    logic [D_W-1:0] px_e, py_e, pcx_e, pcy_e;
    logic           negx_c, negy_c;

    assign px_e   = D_W'({i_pixel_x, 8'h00});
    assign py_e   = D_W'({i_pixel_y, 8'h00});
    assign pcx_e  = D_W'(r_prin_x);
    assign pcy_e  = D_W'(r_prin_y);
    assign negx_c = px_e < pcx_e;
    assign negy_c = py_e < pcy_e;

    logic           r1_vld;
    logic [D_W-1:0] r1_dx, r1_dy;
    logic           r1_negx, r1_negy, r1_zero;
    logic [RDW-1:0] r1_r;

    // ---------------------------------------------------------------- stage 2: products
    logic             r2_vld;
    logic [FXB_W-1:0] r2_fxb;
    logic [DXB_W-1:0] r2_dxb;
    logic [FYR_W-1:0] r2_fyr;
    logic [D_W-1:0]   r2_dy;
    logic             r2_negx, r2_negy, r2_zero, r2_fy0;
    logic [RDW-1:0]   r2_r;

    // ---------------------------------------------------------------- stage 3: y numerator
    logic             r3_vld;
    logic [DYF_W-1:0] r3_dyf;
    logic [FXB_W-1:0] r3_fxb;
    logic [DXB_W-1:0] r3_dxb;
    logic [FYR_W-1:0] r3_fyr;
    logic             r3_negx, r3_negy, r3_zero, r3_fy0;
    logic [RDW-1:0]   r3_r;

    // ---------------------------------------------------------------- stage 4: divider operands
    // rounding half away from zero: q = (2*n + d) / (2*d)
    logic            r4_vld;
    logic [NZ_W-1:0] r4_nz;
    logic [NX_W-1:0] r4_nx;
    logic [NY_W-1:0] r4_ny;
    logic [DZ_W-1:0] r4_dz;
    logic [DY_W-1:0] r4_dy;
    logic            r4_negx, r4_negy, r4_zero, r4_fy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx   <= negx_c ? pcx_e - px_e : px_e - pcx_e;
            r1_dy   <= negy_c ? pcy_e - py_e : py_e - pcy_e;
            r1_negx <= negx_c;
            r1_negy <= negy_c;
            r1_r    <= i_pixel_radius;
            r1_zero <= (i_pixel_radius == '0);

            r2_fxb  <= r_focal_x * r_ball;
            r2_dxb  <= r1_dx * r_ball;
            r2_fyr  <= r_focal_y * r1_r;
            r2_dy   <= r1_dy;
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;
            r2_zero <= r1_zero;
            r2_fy0  <= (r_focal_y == '0);
            r2_r    <= r1_r;

            r3_dyf  <= r2_dy * r2_fxb;
            r3_fxb  <= r2_fxb;
            r3_dxb  <= r2_dxb;
            r3_fyr  <= r2_fyr;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
            r3_zero <= r2_zero;
            r3_fy0  <= r2_fy0;
            r3_r    <= r2_r;

            r4_nz   <= NZ_W'({r3_fxb, 1'b0}) + NZ_W'({r3_r, 9'h000});
            r4_nx   <= NX_W'({r3_dxb, 1'b0}) + NX_W'({r3_r, 9'h000});
            r4_ny   <= NY_W'({r3_dyf, 1'b0}) + NY_W'({r3_fyr, 9'h000});
            r4_dz   <= {r3_r, 10'h000};
            r4_dy   <= {r3_fyr, 10'h000};
            r4_negx <= r3_negx;
            r4_negy <= r3_negy;
            r4_zero <= r3_zero;
            r4_fy0  <= r3_fy0;
        end
    end

    // ---------------------------------------------------------------- three divider lanes
    logic          v_z, v_x, v_y;
    logic [QW-1:0] q_z, q_x, q_y;
    logic          ovf_z, ovf_x, ovf_y;
    logic          t_zero, t_negx;
    logic [1:0]    t_y;

    // depth: Fx*B / 512r
    bpos_div #(.NUM_W(NZ_W), .DEN_W(DZ_W), .TAG_W(1)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_num   (r4_nz),
        .i_den   (r4_dz),
        .i_tag   (r4_zero),
        .o_vld   (v_z),
        .o_q     (q_z),
        .o_ovf   (ovf_z),
        .o_tag   (t_zero)
    );

    // lateral: focal_x cancels, dx*B / 512r
    bpos_div #(.NUM_W(NX_W), .DEN_W(DZ_W), .TAG_W(1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_num   (r4_nx),
        .i_den   (r4_dz),
        .i_tag   (r4_negx),
        .o_vld   (v_x),
        .o_q     (q_x),
        .o_ovf   (ovf_x),
        .o_tag   (t_negx)
    );

    // vertical: dy*Fx*B / (512*Fy*r)
    bpos_div #(.NUM_W(NY_W), .DEN_W(DY_W), .TAG_W(2)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_num   (r4_ny),
        .i_den   (r4_dy),
        .i_tag   ({r4_negy, r4_fy0}),
        .o_vld   (v_y),
        .o_q     (q_y),
        .o_ovf   (ovf_y),
        .o_tag   (t_y)
    );

    // ---------------------------------------------------------------- stage 5: clamp
    logic          t_negy, t_fy0;
    logic          sat_x, sat_y;
    logic [RW-1:0] mag_x, mag_y, mag_z;

    assign t_negy = t_y[1];
    assign t_fy0  = t_y[0];

    // negative side may reach exactly 2^23 without saturating
    assign sat_x = ovf_x | (t_negx ? (q_x[QW-1] & (|q_x[QW-2:0])) : q_x[QW-1]);
    assign sat_y = ovf_y | (t_negy ? (q_y[QW-1] & (|q_y[QW-2:0])) : q_y[QW-1]);

    always_comb begin
        mag_x = q_x;
        mag_y = q_y;
        mag_z = q_z;
        if (sat_x) begin
            mag_x = t_negx ? bpos_pkg::POS_MIN_MAG : bpos_pkg::POS_MAX_MAG;
        end
        if (sat_y) begin
            mag_y = t_negy ? bpos_pkg::POS_MIN_MAG : bpos_pkg::POS_MAX_MAG;
        end
        if (t_fy0) begin
            mag_y = '0;
        end
        if (t_zero) begin
            mag_x = '0;
            mag_y = '0;
            mag_z = '0;
        end
    end

    logic          r5_vld;
    logic [RW-1:0] r5_mx, r5_my, r5_mz;
    logic          r5_negx, r5_negy, r5_err, r5_zero;

    // ---------------------------------------------------------------- stage 6: squares
    logic            r6_vld;
    logic [RW-1:0]   r6_xr, r6_yr;
    logic [SQ_W-1:0] r6_x2, r6_y2, r6_z2;
    logic            r6_err, r6_zero;

    // ---------------------------------------------------------------- stage 7..8: sum
    logic            r7_vld;
    logic [SQ_W-1:0] r7_sxy, r7_z2;
    logic [RW-1:0]   r7_xr, r7_yr;
    logic            r7_err, r7_zero;

    logic            r8_vld;
    logic [SQ_W-1:0] r8_sum;
    logic [RW-1:0]   r8_xr, r8_yr;
    logic            r8_err, r8_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= v_z & v_x & v_y;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx   <= mag_x;
            r5_my   <= mag_y;
            r5_mz   <= mag_z;
            r5_negx <= t_negx;
            r5_negy <= t_negy;
            r5_err  <= sat_x | sat_y | t_fy0 | t_zero | ovf_z;
            r5_zero <= t_zero;

            r6_xr   <= r5_negx ? RW'(-r5_mx) : r5_mx;
            r6_yr   <= r5_negy ? RW'(-r5_my) : r5_my;
            r6_x2   <= r5_mx * r5_mx;
            r6_y2   <= r5_my * r5_my;
            r6_z2   <= r5_mz * r5_mz;
            r6_err  <= r5_err;
            r6_zero <= r5_zero;

            r7_sxy  <= r6_x2 + r6_y2;
            r7_z2   <= r6_z2;
            r7_xr   <= r6_xr;
            r7_yr   <= r6_yr;
            r7_err  <= r6_err;
            r7_zero <= r6_zero;

            r8_sum  <= r7_sxy + r7_z2;
            r8_xr   <= r7_xr;
            r8_yr   <= r7_yr;
            r8_err  <= r7_err;
            r8_zero <= r7_zero;
        end
    end

    // ---------------------------------------------------------------- radicand and root
    bpos_pkg::t_side side_in, side_out;
    logic [SQ_W-1:0] rad;
    logic            rad_neg;
    logic            v_sq;
    logic [RW-1:0]   root;
    logic [RW:0]     root_rem;
    logic [SIDE_W-1:0] side_out_bits;

    // zero radius also forces the range to zero
    assign rad_neg = (r8_sum < r_m2) | r8_zero;
    assign rad     = r8_sum - r_m2;

    always_comb begin
        side_in.neg   = rad_neg;
        side_in.err   = r8_err | rad_neg;
        side_in.pos_x = r8_xr;
        side_in.pos_y = r8_yr;
    end

    bpos_sqrt #(.TAG_W(SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r8_vld),
        .i_rad   (rad),
        .i_tag   (side_in),
        .o_vld   (v_sq),
        .o_root  (root),
        .o_rem   (root_rem),
        .o_tag   (side_out_bits)
    );

    assign side_out = bpos_pkg::t_side'(side_out_bits);

    // ---------------------------------------------------------------- final: round, saturate
    logic [RW:0]   s_rnd;
    logic          s_sat;
    logic [RW-1:0] range_c;

    // round to nearest: rad > s*s + s exactly when remainder exceeds root
    assign s_rnd = {1'b0, root} + {{RW{1'b0}}, (root_rem > {1'b0, root})};
    assign s_sat = s_rnd[RW];

    always_comb begin
        priority if (side_out.neg) begin
            range_c = '0;
        end else if (s_sat) begin
            range_c = bpos_pkg::RANGE_MAX;
        end else begin
            range_c = s_rnd[RW-1:0];
        end
    end

    logic          rf_vld;
    logic [RW-1:0] rf_x, rf_y, rf_rng;
    logic          rf_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_vld <= 1'b0;
        end else if (en) begin
            rf_vld <= v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rf_x   <= side_out.pos_x;
            rf_y   <= side_out.pos_y;
            rf_rng <= range_c;
            rf_err <= side_out.err | (s_sat & !side_out.neg);
        end
    end

    // ---------------------------------------------------------------- output reg and skid
    logic [RW-1:0] r_out_x, r_out_y, r_out_rng;
    logic          r_out_err;
    logic [RW-1:0] r_skid_x, r_skid_y, r_skid_rng;
    logic          r_skid_err;
    logic          out_load;
    logic          skid_load;

    // output register takes a new word when empty or being drained
    assign out_load  = !r_out_vld || i_ready;
    // a word leaving the pipeline with the output blocked parks in the skid entry
    assign skid_load = !out_load && en && rf_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld  <= r_skid_vld | rf_vld;
            r_skid_vld <= 1'b0;
        end else if (skid_load) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_skid_vld) begin
                r_out_x   <= r_skid_x;
                r_out_y   <= r_skid_y;
                r_out_rng <= r_skid_rng;
                r_out_err <= r_skid_err;
            end else begin
                r_out_x   <= rf_x;
                r_out_y   <= rf_y;
                r_out_rng <= rf_rng;
                r_out_err <= rf_err;
            end
        end
        if (skid_load) begin
            r_skid_x   <= rf_x;
            r_skid_y   <= rf_y;
            r_skid_rng <= rf_rng;
            r_skid_err <= rf_err;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_pos_x_mm = r_out_x;
    assign o_pos_y_mm = r_out_y;
    assign o_range_mm = r_out_rng;
    assign o_error    = r_out_err;

`ifndef SYNTH
    // skid entry is only occupied behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a word while output register is empty");

    // skid fills only when the output was blocked on the previous edge
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_ready))
        else $error("skid entry filled without a stalled output");

    // the three divider lanes carry the same word in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_z == v_x) && (v_x == v_y))
        else $error("divider lanes out of step");
`endif

endmodule
